FILE: sv/cpr_pkg.sv
`default_nettype none
package cpr_pkg;

  // Quotient or root bits resolved per pipeline stage in the iterative units.
  localparam int unsigned SPS = 4;

  // Divider quotient width: one bit beyond the 16-bit result range, enough to saturate.
  localparam int unsigned DIV_QW = 17;
  localparam int unsigned DIV_ST = (DIV_QW + SPS - 1) / SPS;

  // Square root of a 40-bit radicand gives a 20-bit root.
  localparam int unsigned SQ_RW = 40;
  localparam int unsigned SQ_QW = SQ_RW / 2;
  localparam int unsigned SQ_ST = (SQ_QW + SPS - 1) / SPS;

  // Velocity divider operands.
  localparam int unsigned VN_W = 28;
  localparam int unsigned VD_W = 12;
  // Push-out divider operands.
  localparam int unsigned PN_W = 34;
  localparam int unsigned PD_W = 21;

  // A quotient magnitude becomes a signed value. An overflowed quotient is clamped
  // to the largest magnitude, which saturates the same way as the true value.
  function automatic logic signed [DIV_QW:0] apply_sign(input logic neg, input logic ovf,
                                                       input logic [DIV_QW-1:0] q);
    logic [DIV_QW-1:0] m;
    m = ovf ? '1 : q;
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [15:0] sat16(input logic signed [DIV_QW+1:0] v);
    logic [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'h7fff;
    end else if (v < -19'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/cpr_div.sv
`default_nettype none
// Pipelined restoring divider. The caller guarantees num_i < den_i * 2**QW.
module cpr_div import cpr_pkg::*; #(
  parameter int unsigned NW = 28,
  parameter int unsigned DW = 12,
  parameter int unsigned QW = 17,
  parameter int unsigned TW = 1,
  localparam int unsigned NST = (QW + SPS - 1) / SPS
) (
  input  wire logic           clk_i,
  input  wire logic [NST-1:0] en_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DW-1:0]  den_i,
  input  wire logic [TW-1:0]  side_i,
  output logic      [QW-1:0]  quo_o,
  output logic      [TW-1:0]  side_o
);

  logic [DW-1:0] rem_d [NST];
  logic [DW-1:0] rem_q [NST];
  logic [QW-1:0] low_d [NST];
  logic [QW-1:0] low_q [NST];
  logic [QW-1:0] quo_d [NST];
  logic [QW-1:0] quo_q [NST];
  logic [DW-1:0] den_d [NST];
  logic [DW-1:0] den_q [NST];
  logic [TW-1:0] side_d [NST];
  logic [TW-1:0] side_q [NST];

  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [TW-1:0] side;
    for (int st = 0; st < NST; st++) begin
      t = '0;
      if (st == 0) begin
        rem  = DW'(num_i >> QW);
        low  = num_i[QW-1:0];
        quo  = '0;
        den  = den_i;
        side = side_i;
      end else begin
        rem  = rem_q[st-1];
        low  = low_q[st-1];
        quo  = quo_q[st-1];
        den  = den_q[st-1];
        side = side_q[st-1];
      end
      for (int j = 0; j < SPS; j++) begin
        if (st * SPS + j < QW) begin
          t   = {rem, low[QW-1]};
          low = {low[QW-2:0], 1'b0};
          if (t >= {1'b0, den}) begin
            rem = DW'(t - {1'b0, den});
            quo = {quo[QW-2:0], 1'b1};
          end else begin
            rem = t[DW-1:0];
            quo = {quo[QW-2:0], 1'b0};
          end
        end
      end
      rem_d[st]  = rem;
      low_d[st]  = low;
      quo_d[st]  = quo;
      den_d[st]  = den;
      side_d[st] = side;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int st = 0; st < NST; st++) begin
      if (en_i[st]) begin
        rem_q[st]  <= rem_d[st];
        low_q[st]  <= low_d[st];
        quo_q[st]  <= quo_d[st];
        den_q[st]  <= den_d[st];
        side_q[st] <= side_d[st];
      end
    end
  end

  assign quo_o  = quo_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule
`default_nettype wire

FILE: sv/cpr_sqrt.sv
`default_nettype none
// Pipelined digit-by-digit integer square root, floor(sqrt(rad_i)).
module cpr_sqrt import cpr_pkg::*; #(
  parameter int unsigned RW = 40,
  parameter int unsigned TW = 1,
  localparam int unsigned QW = RW / 2,
  localparam int unsigned NST = (QW + SPS - 1) / SPS
) (
  input  wire logic           clk_i,
  input  wire logic [NST-1:0] en_i,
  input  wire logic [RW-1:0]  rad_i,
  input  wire logic [TW-1:0]  side_i,
  output logic      [QW-1:0]  root_o,
  output logic      [TW-1:0]  side_o
);

  logic [QW+1:0] rem_d [NST];
  logic [QW+1:0] rem_q [NST];
  logic [QW-1:0] root_d [NST];
  logic [QW-1:0] root_q [NST];
  logic [RW-1:0] rad_d [NST];
  logic [RW-1:0] rad_q [NST];
  logic [TW-1:0] side_d [NST];
  logic [TW-1:0] side_q [NST];

  always_comb begin
    logic [QW+3:0] t;
    logic [QW+3:0] trial;
    logic [QW+1:0] rem;
    logic [QW-1:0] root;
    logic [RW-1:0] rad;
    logic [TW-1:0] side;
    for (int st = 0; st < NST; st++) begin
      t     = '0;
      trial = '0;
      if (st == 0) begin
        rem  = '0;
        root = '0;
        rad  = rad_i;
        side = side_i;
      end else begin
        rem  = rem_q[st-1];
        root = root_q[st-1];
        rad  = rad_q[st-1];
        side = side_q[st-1];
      end
      for (int j = 0; j < SPS; j++) begin
        if (st * SPS + j < QW) begin
          t     = {rem, rad[RW-1:RW-2]};
          rad   = {rad[RW-3:0], 2'b00};
          trial = {2'b00, root, 2'b01};
          if (t >= trial) begin
            rem  = (QW+2)'(t - trial);
            root = {root[QW-2:0], 1'b1};
          end else begin
            rem  = (QW+2)'(t);
            root = {root[QW-2:0], 1'b0};
          end
        end
      end
      rem_d[st]  = rem;
      root_d[st] = root;
      rad_d[st]  = rad;
      side_d[st] = side;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int st = 0; st < NST; st++) begin
      if (en_i[st]) begin
        rem_q[st]  <= rem_d[st];
        root_q[st] <= root_d[st];
        rad_q[st]  <= rad_d[st];
        side_q[st] <= side_d[st];
      end
    end
  end

  assign root_o = root_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule
`default_nettype wire

FILE: sv/circle_pair_collision_response_unit.sv
`default_nettype none
// Channel   Direction  Transfer condition           Contents
// s_axis    in         s_axis_tvalid_i & tready_o    one circle pair, movable flags in tuser
// m_axis    out        m_axis_tvalid_o & tready_i    updated pair, hit flag in tuser
//
// One pair is accepted per cycle while s_axis_tready_o is high, and its result is
// presented on m_axis from the output stage register. The pipeline runs through
// the chain of the square root (5 stages) followed by the push-out divider
// (5 stages), plus the front and back arithmetic stages. The reset clears only
// the stage valid bits.
// Each stage holds its item until the next stage can take it, so a stall on the
// output fills the bubbles first and only then deasserts s_axis_tready_o.
module circle_pair_collision_response_unit import cpr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // pos_a[31:0], vel_a[63:32], radius_a[74:64], mass_a[84:75], pos_b[116:85],
  // vel_b[148:117], radius_b[159:149], mass_b[169:160], zero pad [175:170]
  input  wire logic [175:0] s_axis_tdata_i,
  // movable_flags[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // new_pos_a[31:0], new_vel_a[63:32], new_pos_b[95:64], new_vel_b[127:96]
  output logic      [127:0] m_axis_tdata_o,
  // hit[0]
  output logic      [0:0]   m_axis_tuser_o
);

  // Stage numbering: 0 input, 1..3 front arithmetic, then the square root and
  // velocity dividers, then three push-out stages, the push divider, the output.
  localparam int unsigned ST_A   = 4;
  localparam int unsigned ST_MID = ST_A + SQ_ST;
  localparam int unsigned ST_PD  = ST_MID + 3;
  localparam int unsigned ST_OUT = ST_PD + DIV_ST;
  localparam int unsigned NSTG   = ST_OUT + 1;

  typedef struct packed {
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [11:0] r;
    logic [11:0] adx;
    logic [11:0] ady;
    logic        sdx;
    logic        sdy;
    logic        hit;
    logic        mova;
    logic        movb;
  } geo_t;

  typedef struct packed {
    logic        neg;
    logic        zsum;
    logic        ovf;
    logic [15:0] v1;
  } vside_t;

  typedef struct packed {
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [31:0] nvel_a;
    logic [31:0] nvel_b;
    logic        hit;
    logic        push;
    logic        mova;
    logic        sx;
    logic        sy;
  } mid_t;

  typedef struct packed {
    mid_t b;
    logic ovfx;
  } pside_t;

  // ---------------- Stage valid bits and stall control ----------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // ---------------- Stage 0: input capture ----------------
  logic [169:0] s0_data_q;
  logic [1:0]   s0_flags_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_data_q  <= s_axis_tdata_i[169:0];
      s0_flags_q <= s_axis_tuser_i;
    end
  end

  logic signed [15:0] ax, ay, vax, vay, bx, by, vbx, vby;
  logic [10:0] ra, rb;
  logic [9:0]  ma, mb;

  assign ax  = s0_data_q[31:16];
  assign ay  = s0_data_q[15:0];
  assign vax = s0_data_q[63:48];
  assign vay = s0_data_q[47:32];
  assign ra  = s0_data_q[74:64];
  assign ma  = s0_data_q[84:75];
  assign bx  = s0_data_q[116:101];
  assign by  = s0_data_q[100:85];
  assign vbx = s0_data_q[148:133];
  assign vby = s0_data_q[132:117];
  assign rb  = s0_data_q[159:149];
  assign mb  = s0_data_q[169:160];

  // ---------------- Stage 1: differences and velocity products ----------------
  // For A the numerator is v_a*(m_a-m_b) + 2*m_b*v_b; for B it is
  // -v_b*(m_a-m_b) + 2*m_a*v_a. Four products per axis.
  logic signed [10:0] dm;
  assign dm = $signed({1'b0, ma}) - $signed({1'b0, mb});

  logic signed [16:0] s1_dx_q, s1_dy_q;
  logic [11:0]        s1_r_q;
  logic [10:0]        s1_msum_q;
  logic signed [26:0] s1_pa_x_q, s1_pb_x_q, s1_qa_x_q, s1_qb_x_q;
  logic signed [26:0] s1_pa_y_q, s1_pb_y_q, s1_qa_y_q, s1_qb_y_q;
  logic [31:0]        s1_pos_a_q, s1_pos_b_q, s1_vel_a_q, s1_vel_b_q;
  logic [1:0]         s1_flags_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_dx_q    <= 17'(ax) - 17'(bx);
      s1_dy_q    <= 17'(ay) - 17'(by);
      s1_r_q     <= {1'b0, ra} + {1'b0, rb};
      s1_msum_q  <= {1'b0, ma} + {1'b0, mb};
      s1_pa_x_q  <= vax * dm;
      s1_pb_x_q  <= vbx * dm;
      s1_qa_x_q  <= vbx * $signed({1'b0, mb});
      s1_qb_x_q  <= vax * $signed({1'b0, ma});
      s1_pa_y_q  <= vay * dm;
      s1_pb_y_q  <= vby * dm;
      s1_qa_y_q  <= vby * $signed({1'b0, mb});
      s1_qb_y_q  <= vay * $signed({1'b0, ma});
      s1_pos_a_q <= s0_data_q[31:0];
      s1_pos_b_q <= s0_data_q[116:85];
      s1_vel_a_q <= s0_data_q[63:32];
      s1_vel_b_q <= s0_data_q[148:117];
      s1_flags_q <= s0_flags_q;
    end
  end

  // ---------------- Stage 2: squares, box test, numerators ----------------
  logic [16:0] adx_w, ady_w;
  logic signed [33:0] sqx_w, sqy_w;
  logic [11:0] rm1_w;

  assign adx_w = s1_dx_q[16] ? 17'(-s1_dx_q) : s1_dx_q;
  assign ady_w = s1_dy_q[16] ? 17'(-s1_dy_q) : s1_dy_q;
  assign sqx_w = s1_dx_q * s1_dx_q;
  assign sqy_w = s1_dy_q * s1_dy_q;
  assign rm1_w = s1_r_q - 12'd1;

  logic [32:0] s2_sqx_q, s2_sqy_q;
  logic [23:0] s2_rm1sq_q;
  logic        s2_box_q, s2_rgt1_q;
  logic [11:0] s2_adx_q, s2_ady_q, s2_r_q;
  logic        s2_sdx_q, s2_sdy_q;
  logic [27:0] s2_na_x_q, s2_nb_x_q, s2_na_y_q, s2_nb_y_q;
  logic [10:0] s2_msum_q;
  logic [31:0] s2_pos_a_q, s2_pos_b_q, s2_vel_a_q, s2_vel_b_q;
  logic [1:0]  s2_flags_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_sqx_q   <= sqx_w[32:0];
      s2_sqy_q   <= sqy_w[32:0];
      s2_rm1sq_q <= {12'd0, rm1_w} * {12'd0, rm1_w};
      s2_box_q   <= (adx_w < 17'(s1_r_q)) && (ady_w < 17'(s1_r_q));
      s2_rgt1_q  <= s1_r_q > 12'd1;
      s2_adx_q   <= adx_w[11:0];
      s2_ady_q   <= ady_w[11:0];
      s2_sdx_q   <= s1_dx_q[16];
      s2_sdy_q   <= s1_dy_q[16];
      s2_r_q     <= s1_r_q;
      s2_na_x_q  <= {s1_pa_x_q[26], s1_pa_x_q} + {s1_qa_x_q, 1'b0};
      s2_nb_x_q  <= {s1_qb_x_q, 1'b0} - {s1_pb_x_q[26], s1_pb_x_q};
      s2_na_y_q  <= {s1_pa_y_q[26], s1_pa_y_q} + {s1_qa_y_q, 1'b0};
      s2_nb_y_q  <= {s1_qb_y_q, 1'b0} - {s1_pb_y_q[26], s1_pb_y_q};
      s2_msum_q  <= s1_msum_q;
      s2_pos_a_q <= s1_pos_a_q;
      s2_pos_b_q <= s1_pos_b_q;
      s2_vel_a_q <= s1_vel_a_q;
      s2_vel_b_q <= s1_vel_b_q;
      s2_flags_q <= s1_flags_q;
    end
  end

  // ---------------- Stage 3: hit decision and divider operands ----------------
  logic [33:0] d2_w;
  assign d2_w = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};

  // Velocity divider operands: N = 2|num| + sum, D = 2 sum, rounds to nearest.
  logic [VN_W-1:0] vnum_w [4];
  logic [15:0]     vone_w [4];
  logic [VD_W-1:0] vden_w;

  assign vnum_w[0] = s2_na_x_q;
  assign vnum_w[1] = s2_na_y_q;
  assign vnum_w[2] = s2_nb_x_q;
  assign vnum_w[3] = s2_nb_y_q;
  assign vone_w[0] = s2_vel_a_q[31:16];
  assign vone_w[1] = s2_vel_a_q[15:0];
  assign vone_w[2] = s2_vel_b_q[31:16];
  assign vone_w[3] = s2_vel_b_q[15:0];
  assign vden_w    = {s2_msum_q, 1'b0};

  logic [23:0]     s3_d2_q;
  geo_t            s3_geo_q;
  logic [VN_W-1:0] s3_vn_q [4];
  logic [VD_W-1:0] s3_vd_q;
  vside_t          s3_vs_q [4];

  always_ff @(posedge clk_i) begin
    logic [VN_W-1:0] mag;
    logic [VN_W-1:0] n;
    if (en[3]) begin
      s3_d2_q        <= d2_w[23:0];
      s3_geo_q.pos_a <= s2_pos_a_q;
      s3_geo_q.pos_b <= s2_pos_b_q;
      s3_geo_q.r     <= s2_r_q;
      s3_geo_q.adx   <= s2_adx_q;
      s3_geo_q.ady   <= s2_ady_q;
      s3_geo_q.sdx   <= s2_sdx_q;
      s3_geo_q.sdy   <= s2_sdy_q;
      s3_geo_q.hit   <= s2_box_q && s2_rgt1_q && (d2_w < 34'(s2_rm1sq_q));
      s3_geo_q.mova  <= s2_flags_q[0];
      s3_geo_q.movb  <= s2_flags_q[1];
      s3_vd_q        <= vden_w;
      for (int i = 0; i < 4; i++) begin
        mag = vnum_w[i][VN_W-1] ? VN_W'(-vnum_w[i]) : vnum_w[i];
        n   = {mag[VN_W-2:0], 1'b0} + VN_W'(s2_msum_q);
        s3_vn_q[i]      <= n;
        s3_vs_q[i].neg  <= vnum_w[i][VN_W-1];
        s3_vs_q[i].zsum <= s2_msum_q == '0;
        s3_vs_q[i].ovf  <= VD_W'(n >> DIV_QW) >= vden_w;
        s3_vs_q[i].v1   <= vone_w[i];
      end
    end
  end

  // ---------------- Square root and velocity dividers ----------------
  logic [SQ_QW-1:0] root_w;
  geo_t             geo_w;

  cpr_sqrt #(
    .RW (SQ_RW),
    .TW ($bits(geo_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[ST_A +: SQ_ST]),
    .rad_i  ({s3_d2_q, 16'h0000}),
    .side_i (s3_geo_q),
    .root_o (root_w),
    .side_o (geo_w)
  );

  logic [DIV_QW-1:0] vq_w [4];
  vside_t            vs_w [4];

  for (genvar i = 0; i < 4; i++) begin : g_vdiv
    cpr_div #(
      .NW (VN_W),
      .DW (VD_W),
      .QW (DIV_QW),
      .TW ($bits(vside_t))
    ) u_vdiv (
      .clk_i  (clk_i),
      .en_i   (en[ST_A +: DIV_ST]),
      .num_i  (s3_vn_q[i]),
      .den_i  (s3_vd_q),
      .side_i (s3_vs_q[i]),
      .quo_o  (vq_w[i]),
      .side_o (vs_w[i])
    );
  end

  // ---------------- Stage MID: penetration depth and final velocities ----------------
  logic [15:0] nv_w [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!geo_w.hit || vs_w[i].zsum) begin
        nv_w[i] = vs_w[i].v1;
      end else begin
        nv_w[i] = sat16((DIV_QW+2)'(apply_sign(vs_w[i].neg, vs_w[i].ovf, vq_w[i])));
      end
    end
  end

  logic [20:0] f_w;
  assign f_w = {1'b0, geo_w.r, 8'h00} - {1'b0, root_w};

  mid_t             m9_q;
  logic [19:0]      m9_f_q;
  logic [SQ_QW-1:0] m9_s_q;
  logic [11:0]      m9_adx_q, m9_ady_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MID]) begin
      m9_q.pos_a  <= geo_w.pos_a;
      m9_q.pos_b  <= geo_w.pos_b;
      m9_q.nvel_a <= {nv_w[0], nv_w[1]};
      m9_q.nvel_b <= {nv_w[2], nv_w[3]};
      m9_q.hit    <= geo_w.hit;
      m9_q.push   <= geo_w.hit && (root_w != '0) && (geo_w.mova != geo_w.movb);
      m9_q.mova   <= geo_w.mova;
      m9_q.sx     <= geo_w.sdx;
      m9_q.sy     <= geo_w.sdy;
      m9_f_q      <= f_w[19:0];
      m9_s_q      <= root_w;
      m9_adx_q    <= geo_w.adx;
      m9_ady_q    <= geo_w.ady;
    end
  end

  // ---------------- Push-out numerators ----------------
  mid_t             m10_q;
  logic [31:0]      m10_magx_q, m10_magy_q;
  logic [SQ_QW-1:0] m10_s_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MID+1]) begin
      m10_q      <= m9_q;
      m10_magx_q <= m9_adx_q * m9_f_q;
      m10_magy_q <= m9_ady_q * m9_f_q;
      m10_s_q    <= m9_s_q;
    end
  end

  logic [PN_W-1:0] pnx_w, pny_w;
  logic [PD_W-1:0] pd_w;
  assign pnx_w = {1'b0, m10_magx_q, 1'b0} + PN_W'(m10_s_q);
  assign pny_w = {1'b0, m10_magy_q, 1'b0} + PN_W'(m10_s_q);
  assign pd_w  = {m10_s_q, 1'b0};

  pside_t          m11_q;
  logic            m11_ovfy_q;
  logic [PN_W-1:0] m11_nx_q, m11_ny_q;
  logic [PD_W-1:0] m11_d_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MID+2]) begin
      m11_q.b    <= m10_q;
      m11_q.ovfx <= PD_W'(pnx_w >> DIV_QW) >= pd_w;
      m11_ovfy_q <= PD_W'(pny_w >> DIV_QW) >= pd_w;
      m11_nx_q   <= pnx_w;
      m11_ny_q   <= pny_w;
      m11_d_q    <= pd_w;
    end
  end

  // ---------------- Push-out dividers ----------------
  logic [DIV_QW-1:0] pqx_w, pqy_w;
  pside_t            ps_w;
  logic              povfy_w;

  cpr_div #(
    .NW (PN_W),
    .DW (PD_W),
    .QW (DIV_QW),
    .TW ($bits(pside_t))
  ) u_pdiv_x (
    .clk_i  (clk_i),
    .en_i   (en[ST_PD +: DIV_ST]),
    .num_i  (m11_nx_q),
    .den_i  (m11_d_q),
    .side_i (m11_q),
    .quo_o  (pqx_w),
    .side_o (ps_w)
  );

  cpr_div #(
    .NW (PN_W),
    .DW (PD_W),
    .QW (DIV_QW),
    .TW (1)
  ) u_pdiv_y (
    .clk_i  (clk_i),
    .en_i   (en[ST_PD +: DIV_ST]),
    .num_i  (m11_ny_q),
    .den_i  (m11_d_q),
    .side_i (m11_ovfy_q),
    .quo_o  (pqy_w),
    .side_o (povfy_w)
  );

  // ---------------- Output stage: apply push-out with saturation ----------------
  logic signed [DIV_QW:0]   px_w, py_w;
  logic signed [DIV_QW+1:0] pax_w, pay_w, pbx_w, pby_w;
  logic [31:0] npa_w, npb_w;

  assign px_w = apply_sign(ps_w.b.sx, ps_w.ovfx, pqx_w);
  assign py_w = apply_sign(ps_w.b.sy, povfy_w, pqy_w);

  assign pax_w = $signed({{3{ps_w.b.pos_a[31]}}, ps_w.b.pos_a[31:16]}) + $signed({px_w[DIV_QW], px_w});
  assign pay_w = $signed({{3{ps_w.b.pos_a[15]}}, ps_w.b.pos_a[15:0]}) + $signed({py_w[DIV_QW], py_w});
  assign pbx_w = $signed({{3{ps_w.b.pos_b[31]}}, ps_w.b.pos_b[31:16]}) - $signed({px_w[DIV_QW], px_w});
  assign pby_w = $signed({{3{ps_w.b.pos_b[15]}}, ps_w.b.pos_b[15:0]}) - $signed({py_w[DIV_QW], py_w});

  always_comb begin
    npa_w = ps_w.b.pos_a;
    npb_w = ps_w.b.pos_b;
    if (ps_w.b.push) begin
      if (ps_w.b.mova) begin
        npa_w = {sat16(pax_w), sat16(pay_w)};
      end else begin
        npb_w = {sat16(pbx_w), sat16(pby_w)};
      end
    end
  end

  logic [127:0] out_data_q;
  logic         out_hit_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_data_q <= {ps_w.b.nvel_b, npb_w, ps_w.b.nvel_a, npa_w};
      out_hit_q  <= ps_w.b.hit;
    end
  end

  assign m_axis_tvalid_o   = v_q[NSTG-1];
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_hit_q;

  // ---------------- Assertions ----------------
  // An accepted transfer always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted transfer not captured in the input stage");

  // The stalled stage just before the output stage keeps its item.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT-1] && !en[ST_OUT-1] |=> v_q[ST_OUT-1])
    else $error("stalled pipeline stage lost its item");

  // A push-out is only scheduled for a pair that actually collided.
  a_push_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_MID+1] && m10_q.push |-> m10_q.hit)
    else $error("push-out scheduled without a hit");

endmodule
`default_nettype wire
